[src/aat_pkg.sv]
// Package for the box affine transform: configuration layout, register indexes
// and pipeline control types. No dependencies.
package aat_pkg;

  localparam int NUM_AXES    = 3;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 12;
  localparam int ROW_W       = NUM_AXES * COEF_W;
  localparam int OFFS_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int PIPE_STAGES = 5;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0]  row;
    logic [NUM_AXES-1:0][OFFS_W-1:0] offset;
  } aat_cfg_t;

  typedef struct packed {
    logic [PIPE_STAGES-1:0] load;
  } pipe_en_t;

endpackage

[src/aat_if.sv]
// Channel interfaces for the box affine transform: input box, result box and
// configuration write. Depends on aat_pkg.
interface aat_box_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_min_x;
  logic signed [COORD_WIDTH-1:0] in_min_y;
  logic signed [COORD_WIDTH-1:0] in_min_z;
  logic signed [COORD_WIDTH-1:0] in_max_x;
  logic signed [COORD_WIDTH-1:0] in_max_y;
  logic signed [COORD_WIDTH-1:0] in_max_z;

  modport source (output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
                  input ready);
  modport sink (input valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
                output ready);
endinterface

interface aat_result_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_min_x;
  logic signed [COORD_WIDTH-1:0] out_min_y;
  logic signed [COORD_WIDTH-1:0] out_min_z;
  logic signed [COORD_WIDTH-1:0] out_max_x;
  logic signed [COORD_WIDTH-1:0] out_max_y;
  logic signed [COORD_WIDTH-1:0] out_max_z;
  logic                          saturated;

  modport source (output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                  out_max_z, saturated, input ready);
  modport sink (input valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y,
                out_max_z, saturated, output ready);
endinterface

interface aat_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [aat_pkg::CFG_IDX_W-1:0]    index;
  logic [aat_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/aat_cfg_regs.sv]
// Configuration register file: three coefficient rows and three offsets.
// Depends on aat_pkg and aat_cfg_if.
module aat_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  aat_cfg_if.sink           cfg_ch,
  output aat_pkg::aat_cfg_t cfg
);

  aat_pkg::aat_cfg_t cfg_r;
  aat_pkg::aat_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (aat_pkg::cfg_reg_t'(cfg_ch.index))
        aat_pkg::REG_ROW_X:    cfg_nxt.row[0]    = cfg_ch.data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW_Y:    cfg_nxt.row[1]    = cfg_ch.data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW_Z:    cfg_nxt.row[2]    = cfg_ch.data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_OFFSET_X: cfg_nxt.offset[0] = cfg_ch.data[aat_pkg::OFFS_W-1:0];
        aat_pkg::REG_OFFSET_Y: cfg_nxt.offset[1] = cfg_ch.data[aat_pkg::OFFS_W-1:0];
        aat_pkg::REG_OFFSET_Z: cfg_nxt.offset[2] = cfg_ch.data[aat_pkg::OFFS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row[0]    <= aat_pkg::ROW_X_RESET;
      cfg_r.row[1]    <= aat_pkg::ROW_Y_RESET;
      cfg_r.row[2]    <= aat_pkg::ROW_Z_RESET;
      cfg_r.offset    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[src/aat_pipe_ctrl.sv]
// Valid bits and per-stage load enables of the transform pipeline, with
// backpressure from the result channel. Depends on aat_pkg.
module aat_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aat_pkg::pipe_en_t en
);

  localparam int N = aat_pkg::PIPE_STAGES;

  logic [N-1:0] valid_r;
  logic [N-1:0] valid_nxt;
  logic [N-1:0] load;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    load[N-1] = !valid_r[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int k = 1; k < N; k++) begin
      valid_nxt[k] = load[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign en.load   = load;
  assign in_ready  = load[0];
  assign out_valid = valid_r[N-1];

endmodule

[src/aat_axis.sv]
// Datapath of one output axis: products, min/max ordering, offset sum and
// saturation, four register stages. Depends on aat_pkg.
module aat_axis #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  aat_pkg::pipe_en_t             en,
  input  logic [aat_pkg::ROW_W-1:0]     row,
  input  logic [aat_pkg::OFFS_W-1:0]    offset,
  input  logic signed [COORD_WIDTH-1:0] box_min [aat_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0] box_max [aat_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0] lo,
  output logic signed [COORD_WIDTH-1:0] hi,
  output logic                          sat
);

  localparam int NA = aat_pkg::NUM_AXES;
  localparam int PW = COORD_WIDTH + aat_pkg::COEF_W;
  localparam int TW = PW - aat_pkg::FRAC_BITS;
  localparam int SW = ((TW > aat_pkg::OFFS_W) ? TW : aat_pkg::OFFS_W) + 2;
  localparam int HW = SW - COORD_WIDTH + 1;

  logic signed [PW-1:0]          prod_min_r [NA];
  logic signed [PW-1:0]          prod_max_r [NA];
  logic signed [TW-1:0]          term_lo_r  [NA];
  logic signed [TW-1:0]          term_hi_r  [NA];
  logic signed [SW-1:0]          sum_lo_r;
  logic signed [SW-1:0]          sum_hi_r;
  logic signed [SW-1:0]          sum_lo_nxt;
  logic signed [SW-1:0]          sum_hi_nxt;
  logic signed [COORD_WIDTH-1:0] lo_r;
  logic signed [COORD_WIDTH-1:0] hi_r;
  logic                          sat_r;
  logic signed [COORD_WIDTH-1:0] lo_nxt;
  logic signed [COORD_WIDTH-1:0] hi_nxt;
  logic                          lo_ovf;
  logic                          hi_ovf;
  logic [HW-1:0]                 lo_top;
  logic [HW-1:0]                 hi_top;

  for (genvar j = 0; j < NA; j++) begin : g_term
    logic signed [aat_pkg::COEF_W-1:0] coef;
    logic signed [TW-1:0]              ta;
    logic signed [TW-1:0]              tb;

    assign coef = $signed(row[j*aat_pkg::COEF_W +: aat_pkg::COEF_W]);
    // Dropping the low fraction bits of a signed product rounds toward minus infinity.
    assign ta = $signed(prod_min_r[j][PW-1:aat_pkg::FRAC_BITS]);
    assign tb = $signed(prod_max_r[j][PW-1:aat_pkg::FRAC_BITS]);

    always_ff @(posedge clk) begin
      if (en.load[1]) begin
        prod_min_r[j] <= coef * box_min[j];
        prod_max_r[j] <= coef * box_max[j];
      end
      if (en.load[2]) begin
        if (ta < tb) begin
          term_lo_r[j] <= ta;
          term_hi_r[j] <= tb;
        end else begin
          term_lo_r[j] <= tb;
          term_hi_r[j] <= ta;
        end
      end
    end
  end

  always_comb begin
    sum_lo_nxt = SW'($signed(offset));
    sum_hi_nxt = SW'($signed(offset));
    for (int j = 0; j < NA; j++) begin
      sum_lo_nxt = sum_lo_nxt + SW'(term_lo_r[j]);
      sum_hi_nxt = sum_hi_nxt + SW'(term_hi_r[j]);
    end
  end

  // A sum is out of range when the coordinate sign bit and the bits above it differ.
  always_comb begin
    lo_top = sum_lo_r[SW-1:COORD_WIDTH-1];
    hi_top = sum_hi_r[SW-1:COORD_WIDTH-1];
    lo_ovf = !((&lo_top) || !(|lo_top));
    hi_ovf = !((&hi_top) || !(|hi_top));
    if (lo_ovf) begin
      lo_nxt = sum_lo_r[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      lo_nxt = sum_lo_r[COORD_WIDTH-1:0];
    end
    if (hi_ovf) begin
      hi_nxt = sum_hi_r[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      hi_nxt = sum_hi_r[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.load[3]) begin
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
    end
    if (en.load[4]) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      sat_r <= lo_ovf || hi_ovf;
    end
  end

  assign lo  = lo_r;
  assign hi  = hi_r;
  assign sat = sat_r;

endmodule

[src/aabb_affine_transform.sv]
// Top level of the box affine transform: input stage, three axis datapaths,
// pipeline control and configuration registers. Depends on aat_pkg, aat_if.sv,
// aat_cfg_regs, aat_pipe_ctrl and aat_axis.
//
//   Channel   Direction  Payload
//   in_ch     sink       in_min_x/y/z, in_max_x/y/z
//   out_ch    source     out_min_x/y/z, out_max_x/y/z, saturated
//   cfg_ch    sink       index (3 bits), data (48 bits)
//
// One box enters per cycle unless back-pressure holds the input; it then moves
// through input register, multiply, min/max ordering, offset sum, saturation.
// Reset is synchronous and active low; it clears the valid bits and loads the
// identity transform with zero offset.
// A stalled result holds full stages with no gap after them; gaps keep filling.
// Configuration writes are taken every cycle and are meant for an idle pipeline.
module aabb_affine_transform #(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  aat_box_if.sink       in_ch,
  aat_result_if.source  out_ch,
  aat_cfg_if.sink       cfg_ch
);

  localparam int NA = aat_pkg::NUM_AXES;

  aat_pkg::aat_cfg_t             cfg;
  aat_pkg::pipe_en_t             en;
  logic signed [COORD_WIDTH-1:0] box_min_r [NA];
  logic signed [COORD_WIDTH-1:0] box_max_r [NA];
  logic signed [COORD_WIDTH-1:0] lo [NA];
  logic signed [COORD_WIDTH-1:0] hi [NA];
  logic [NA-1:0]                 sat;

  aat_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  aat_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  always_ff @(posedge clk) begin
    if (en.load[0]) begin
      box_min_r[0] <= in_ch.in_min_x;
      box_min_r[1] <= in_ch.in_min_y;
      box_min_r[2] <= in_ch.in_min_z;
      box_max_r[0] <= in_ch.in_max_x;
      box_max_r[1] <= in_ch.in_max_y;
      box_max_r[2] <= in_ch.in_max_z;
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_axis
    aat_axis #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_axis (
      .clk     (clk),
      .en      (en),
      .row     (cfg.row[i]),
      .offset  (cfg.offset[i]),
      .box_min (box_min_r),
      .box_max (box_max_r),
      .lo      (lo[i]),
      .hi      (hi[i]),
      .sat     (sat[i])
    );
  end

  assign out_ch.out_min_x = lo[0];
  assign out_ch.out_min_y = lo[1];
  assign out_ch.out_min_z = lo[2];
  assign out_ch.out_max_x = hi[0];
  assign out_ch.out_max_y = hi[1];
  assign out_ch.out_max_z = hi[2];
  assign out_ch.saturated = |sat;

endmodule

[bench/aabb_transform_checker.sv]
`timescale 1ns / 100ps
// Checker for aabb_affine_transform: follows the configuration, box and result
// channels, predicts each transformed box and compares every result field.
// Depends on aat_pkg and the channel interfaces of aat_if.sv.
module aabb_transform_checker #(
  parameter int CW = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  aat_box_if    box_ch,
  aat_result_if res_ch,
  aat_cfg_if    cfg_ch,
  output int    mismatches,
  output int    outstanding
);

  typedef logic [aat_pkg::NUM_AXES-1:0][CW-1:0] coord3_t;
  typedef struct packed {
    coord3_t lo;
    coord3_t hi;
    logic    sat;
  } bounds_t;

  logic [aat_pkg::NUM_AXES-1:0][aat_pkg::ROW_W-1:0]  coef_rows;
  logic [aat_pkg::NUM_AXES-1:0][aat_pkg::OFFS_W-1:0] offsets;
  bounds_t                                           expected_bounds [$];
  bounds_t                                           want;
  bounds_t                                           got;
  int                                                fail_total = 0;
  string                                             axis_tag [aat_pkg::NUM_AXES] =
                                                       '{"x", "y", "z"};

  function automatic logic [CW-1:0] clamp_coord(longint v, inout logic clamped);
    longint hi_lim = (longint'(1) <<< (CW - 1)) - 1;
    longint lo_lim = -hi_lim - 1;
    if (v > hi_lim) begin
      clamped = 1'b1;
      return CW'(hi_lim);
    end
    if (v < lo_lim) begin
      clamped = 1'b1;
      return CW'(lo_lim);
    end
    return CW'(v);
  endfunction

  // Each product of a Q4.12 coefficient is floored to the coordinate scale; the
  // smaller term goes to the low sum, so an inverted box still gives lo <= hi.
  function automatic bounds_t transform_box(coord3_t mn, coord3_t mx);
    bounds_t res;
    logic    clamped;
    longint  lo_sum;
    longint  hi_sum;
    longint  coef;
    longint  a;
    longint  b;
    clamped = 1'b0;
    for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
      lo_sum = longint'($signed(offsets[i]));
      hi_sum = lo_sum;
      for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
        coef = longint'($signed(coef_rows[i][aat_pkg::COEF_W*j +: aat_pkg::COEF_W]));
        a = (coef * longint'($signed(mn[j]))) >>> aat_pkg::FRAC_BITS;
        b = (coef * longint'($signed(mx[j]))) >>> aat_pkg::FRAC_BITS;
        if (a < b) begin
          lo_sum += a;
          hi_sum += b;
        end else begin
          lo_sum += b;
          hi_sum += a;
        end
      end
      res.lo[i] = clamp_coord(lo_sum, clamped);
      res.hi[i] = clamp_coord(hi_sum, clamped);
    end
    res.sat = clamped;
    return res;
  endfunction

  task automatic check_field(string name, logic [CW-1:0] want_v, logic [CW-1:0] got_v);
    if (got_v !== want_v) begin
      fail_total++;
      $error("%s: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coef_rows <= {aat_pkg::ROW_Z_RESET, aat_pkg::ROW_Y_RESET, aat_pkg::ROW_X_RESET};
      offsets <= '0;
      expected_bounds.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          aat_pkg::REG_ROW_X:    coef_rows[0] <= cfg_ch.data;
          aat_pkg::REG_ROW_Y:    coef_rows[1] <= cfg_ch.data;
          aat_pkg::REG_ROW_Z:    coef_rows[2] <= cfg_ch.data;
          aat_pkg::REG_OFFSET_X: offsets[0] <= cfg_ch.data[aat_pkg::OFFS_W-1:0];
          aat_pkg::REG_OFFSET_Y: offsets[1] <= cfg_ch.data[aat_pkg::OFFS_W-1:0];
          aat_pkg::REG_OFFSET_Z: offsets[2] <= cfg_ch.data[aat_pkg::OFFS_W-1:0];
          default: ;
        endcase
      end
      if (box_ch.valid && box_ch.ready) begin
        expected_bounds.push_back(transform_box(
          {box_ch.in_min_z, box_ch.in_min_y, box_ch.in_min_x},
          {box_ch.in_max_z, box_ch.in_max_y, box_ch.in_max_x}));
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_bounds.size() == 0) begin
          fail_total++;
          $error("Result transaction arrived with no box outstanding.");
        end else begin
          want = expected_bounds.pop_front();
          got.lo = {res_ch.out_min_z, res_ch.out_min_y, res_ch.out_min_x};
          got.hi = {res_ch.out_max_z, res_ch.out_max_y, res_ch.out_max_x};
          got.sat = res_ch.saturated;
          for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
            check_field({"out_min_", axis_tag[i]}, want.lo[i], got.lo[i]);
            check_field({"out_max_", axis_tag[i]}, want.hi[i], got.hi[i]);
          end
          check_field("saturated", CW'(want.sat), CW'(got.sat));
        end
      end
    end
    mismatches <= fail_total;
    outstanding <= expected_bounds.size();
  end

endmodule

[bench/aabb_affine_transform_tb.sv]
`timescale 1ns / 100ps
// Testbench top for aabb_affine_transform: clock, reset, box and configuration
// stimulus, result back-pressure and the verdict. Depends on aat_pkg, the
// interfaces of aat_if.sv and aabb_transform_checker.
module aabb_affine_transform_tb;

  localparam int CW              = 32;
  localparam int IDLE_PCT        = 23;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 8;
  localparam int BOXES_PER_PHASE = 230;

  localparam logic [aat_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [aat_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam logic [CW-1:0]              C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0]              C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [aat_pkg::COEF_W-1:0] K_MIN = 16'h8000;
  localparam logic [aat_pkg::COEF_W-1:0] K_MAX = 16'h7FFF;
  localparam logic [aat_pkg::COEF_W-1:0] K_ONE = 16'h1000;
  localparam logic [aat_pkg::OFFS_W-1:0] O_MIN = 32'h8000_0000;
  localparam logic [aat_pkg::OFFS_W-1:0] O_MAX = 32'h7FFF_FFFF;

  typedef logic [aat_pkg::NUM_AXES-1:0][CW-1:0]              coord3_t;
  typedef logic [aat_pkg::NUM_AXES-1:0][aat_pkg::COEF_W-1:0] coef3_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   steady;
  bit   hold_wanted;
  int   mismatches;
  int   outstanding;

  aat_box_if #(.COORD_WIDTH(CW))    in_ch();
  aat_result_if #(.COORD_WIDTH(CW)) out_ch();
  aat_cfg_if                        cfg_ch();

  aabb_affine_transform #(.COORD_WIDTH(CW)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  aabb_transform_checker #(.CW(CW)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .box_ch      (in_ch),
    .res_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** aabb_affine_transform: FAILED **");
    $finish;
  end

  // The receiver stalls at random, and once holds off long enough for the
  // pipeline to fill and push back on the box channel.
  initial begin : result_sink
    int held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && held < HOLD_CYCLES) begin
        held++;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic coord3_t box3(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [47:0] wide_rand();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [CW-1:0] extreme_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      4: return CW'(1);
      default: return C_MIN + CW'(1);
    endcase
  endfunction

  function automatic logic [CW-1:0] small_coord();
    return CW'($urandom_range(0, 32'h20_0000)) - CW'(32'h10_0000);
  endfunction

  function automatic logic [aat_pkg::COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 6))
      0: return K_MIN;
      1: return K_MAX;
      2: return '0;
      3: return K_ONE;
      4: return -K_ONE;
      5: return aat_pkg::COEF_W'(1);
      default: return '1;
    endcase
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (aat_pkg::PIPE_STAGES) @(posedge clk);
  endtask

  task automatic put_reg(logic [aat_pkg::CFG_IDX_W-1:0] idx,
                         logic [aat_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Offsets are passed at full register width so that the ignored upper
  // bits of the write data carry junk.
  task automatic load_transform(coef3_t rx, coef3_t ry, coef3_t rz,
                                logic [47:0] ox, logic [47:0] oy, logic [47:0] oz,
                                bit spare);
    wait_idle();
    put_reg(aat_pkg::REG_ROW_X, rx);
    put_reg(aat_pkg::REG_ROW_Y, ry);
    put_reg(aat_pkg::REG_ROW_Z, rz);
    put_reg(aat_pkg::REG_OFFSET_X, ox);
    put_reg(aat_pkg::REG_OFFSET_Y, oy);
    put_reg(aat_pkg::REG_OFFSET_Z, oz);
    if (spare) begin
      put_reg(IDX_SPARE_LO, wide_rand());
      put_reg(IDX_SPARE_HI, wide_rand());
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_box(coord3_t mn, coord3_t mx);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_min_x <= mn[0];
    in_ch.in_min_y <= mn[1];
    in_ch.in_min_z <= mn[2];
    in_ch.in_max_x <= mx[0];
    in_ch.in_max_y <= mx[1];
    in_ch.in_max_z <= mx[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_box();
    coord3_t     mn;
    coord3_t     mx;
    logic [CW-1:0] t;
    int          mode;
    mode = $urandom_range(0, 99);
    for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
      if (mode < 40) begin
        mn[j] = CW'($urandom());
        mx[j] = CW'($urandom());
      end else if (mode < 80) begin
        mn[j] = small_coord();
        mx[j] = small_coord();
        if (($signed(mn[j]) > $signed(mx[j])) == (mode < 72)) begin
          t = mn[j];
          mn[j] = mx[j];
          mx[j] = t;
        end
      end else begin
        mn[j] = extreme_coord();
        mx[j] = extreme_coord();
      end
    end
    send_box(mn, mx);
  endtask

  task automatic load_random_transform(int kind);
    coef3_t      rows [aat_pkg::NUM_AXES];
    logic [47:0] offs [aat_pkg::NUM_AXES];
    for (int i = 0; i < aat_pkg::NUM_AXES; i++) begin
      for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
        case (kind)
          0: rows[i][j] = aat_pkg::COEF_W'($urandom());
          1: rows[i][j] = aat_pkg::COEF_W'($urandom_range(0, 16'h2000)) - K_ONE;
          default: rows[i][j] = extreme_coef();
        endcase
      end
      case (kind)
        0: offs[i] = wide_rand();
        1: offs[i] = {16'($urandom()),
                      32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000};
        default: offs[i] = {16'($urandom()), $urandom_range(0, 1) ? O_MAX : O_MIN};
      endcase
    end
    load_transform(rows[0], rows[1], rows[2], offs[0], offs[1], offs[2],
                   bit'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.in_min_x <= '0;
    in_ch.in_min_y <= '0;
    in_ch.in_min_z <= '0;
    in_ch.in_max_x <= '0;
    in_ch.in_max_y <= '0;
    in_ch.in_max_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Identity transform straight out of reset, including an inverted box.
    send_box(box3(0, 0, 0), box3(0, 0, 0));
    send_box(box3(C_MIN, C_MIN, C_MIN), box3(C_MAX, C_MAX, C_MAX));
    send_box(box3(32'h0003_0000, 32'h0001_8000, '1), box3(32'hFFFE_0000, 0, C_MIN));
    send_box(box3(32'h0001_8000, 32'hFFFF_8000, 1), box3(32'h0002_0000, 32'h4000, 32'h10_0000));

    // Most negative coefficients with the largest offset drive saturation.
    load_transform({3{K_MIN}}, {3{K_MIN}}, {3{K_MIN}},
                   {16'hFFFF, O_MAX}, {16'hFFFF, O_MAX}, {16'hFFFF, O_MAX}, 1'b1);
    send_box(box3(C_MIN, C_MIN, C_MIN), box3(C_MAX, C_MAX, C_MAX));
    send_box(box3(0, 0, 0), box3(0, 0, 0));
    send_box(box3('1, '1, '1), box3(1, 1, 1));

    load_transform({3{K_MAX}}, {3{K_MAX}}, {3{K_MAX}},
                   {16'h0000, O_MIN}, {16'h5A5A, O_MIN}, {16'hFFFF, O_MIN}, 1'b0);
    send_box(box3(C_MIN, C_MIN, C_MIN), box3(C_MAX, C_MAX, C_MAX));
    send_box(box3(0, 0, 0), box3(0, 0, 0));
    send_box(box3(C_MAX, C_MAX, C_MAX), box3(C_MAX, C_MAX, C_MAX));

    // Tiny and negative products check the floor toward minus infinity.
    load_transform({16'h0000, 16'hFFFF, 16'h0001}, {16'h0800, 16'hF800, 16'h0000},
                   {16'h0001, 16'h0000, 16'hFFFF},
                   {16'h0000, 32'h0000_0001}, {16'hABCD, 32'hFFFF_FFFF}, 48'h0, 1'b0);
    send_box(box3('1, '1, '1), box3(1, 1, 1));
    send_box(box3(32'hFFFF_F001, 32'h0000_0FFF, C_MIN),
             box3(32'h0000_1000, 32'hFFFF_EFFF, C_MAX));
    send_box(box3(32'h0000_0FFF, 32'h7000_0000, 32'hFFFF_FFFE),
             box3(32'hFFFF_F000, 32'h9000_0000, 32'h0000_0003));

    load_transform(48'h0, 48'h0, 48'h0, wide_rand(), wide_rand(), wide_rand(), 1'b1);
    send_box(box3(C_MIN, C_MAX, C_MIN), box3(C_MAX, C_MIN, C_MAX));

    for (int p = 0; p < PHASES; p++) begin
      load_random_transform(p % 3);
      steady <= (p == 1);
      if (p == 3)
        hold_wanted <= 1'b1;
      for (int k = 0; k < BOXES_PER_PHASE; k++)
        send_random_box();
    end

    wait_idle();
    repeat (2 * aat_pkg::PIPE_STAGES) @(posedge clk);
    if (mismatches == 0)
      $display("** aabb_affine_transform: PASSED **");
    else
      $display("** aabb_affine_transform: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
src/aat_pkg.sv
src/aat_if.sv
src/aat_cfg_regs.sv
src/aat_pipe_ctrl.sv
src/aat_axis.sv
src/aabb_affine_transform.sv
bench/aabb_transform_checker.sv
bench/aabb_affine_transform_tb.sv
